>>> rtl/qsw_pkg.sv
// Shared types and constants for the quintic switching-function pipeline.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package qsw_pkg;

    // Fraction bits of distance-type quantities
    localparam int DIST_FRAC_BITS = 16;

    // Pipeline depth: three front stages for u, five back stages for the polynomials
    localparam int NUM_STAGES   = 8;
    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES  = NUM_STAGES - FRONT_STAGES;

    // Split point of the 48-bit reciprocal into two 24-bit halves
    localparam int INV_SPLIT = 24;

    // Right shift that turns g * inverse_width into Q16.32 slope units
    localparam int SLOPE_SHIFT = INV_SPLIT - DIST_FRAC_BITS;

    // Fixed-point constants
    localparam logic [32:0] ONE_Q32       = 33'h1_0000_0000;
    localparam logic [36:0] TEN_Q32       = 37'h0A_0000_0000;
    localparam logic [31:0] RND31         = 32'h8000_0000;
    localparam logic [15:0] RND15         = 16'h8000;
    localparam logic [47:0] SLOPE_MAG_MAX = 48'h8000_0000_0000;

    // Configuration register indexes
    localparam logic [1:0] REG_START_DISTANCE = 2'd0;
    localparam logic [1:0] REG_SWITCH_WIDTH   = 2'd1;
    localparam logic [1:0] REG_INVERSE_WIDTH  = 2'd2;

    // Configuration reset values
    localparam logic [31:0] START_DISTANCE_RST = 32'd0;
    localparam logic [31:0] SWITCH_WIDTH_RST   = 32'd65536;
    localparam logic [47:0] INVERSE_WIDTH_RST  = 48'h0001_0000_0000;

    // Region codes
    typedef enum logic [1:0] {
        REGION_INSIDE = 2'd0,
        REGION_SWITCH = 2'd1,
        REGION_BEYOND = 2'd2
    } region_t;

    // Configuration register bundle
    typedef struct packed {
        logic [31:0] start_distance;
        logic [31:0] switch_width;
        logic [47:0] inverse_width;
    } cfg_t;

endpackage

>>> rtl/qsw_ctrl.sv
// Valid tracking and per-stage load enables for the switching-function pipeline.
// Depends on qsw_pkg for the stage count.
module qsw_ctrl
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [qsw_pkg::NUM_STAGES-1:0]   load
);

    logic [qsw_pkg::NUM_STAGES-1:0] valid_reg;
    logic [qsw_pkg::NUM_STAGES-1:0] valid_next;
    logic [qsw_pkg::NUM_STAGES-1:0] ready;

    // A stage may load when it is empty or its content moves on
    always_comb
    begin
        ready[qsw_pkg::NUM_STAGES-1] = !valid_reg[qsw_pkg::NUM_STAGES-1] || !out_stall;
        for (int k = qsw_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    // Advance valid bits with the data
    always_comb
    begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < qsw_pkg::NUM_STAGES; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign load      = ready;
    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[qsw_pkg::NUM_STAGES-1];

endmodule

>>> rtl/qsw_upos.sv
// Front stages: region classification, offset from start and unit position u (Q0.32).
// Depends on qsw_pkg for the configuration bundle, region codes and constants.
module qsw_upos
(
    input  logic                                  clk,
    input  logic [qsw_pkg::FRONT_STAGES-1:0]      load,
    input  qsw_pkg::cfg_t                         cfg,
    input  logic [31:0]                           distance,
    output logic [31:0]                           u,
    output qsw_pkg::region_t                      region
);

    // Stage 1: classify and take the offset
    logic [32:0]       end_dist;
    qsw_pkg::region_t  s1_region_next;
    qsw_pkg::region_t  s1_region_reg;
    logic [31:0]       s1_d_next;
    logic [31:0]       s1_d_reg;

    always_comb
    begin
        end_dist = {1'b0, cfg.start_distance} + {1'b0, cfg.switch_width};
        if (distance <= cfg.start_distance)
        begin
            s1_region_next = qsw_pkg::REGION_INSIDE;
        end
        else if ({1'b0, distance} >= end_dist)
        begin
            s1_region_next = qsw_pkg::REGION_BEYOND;
        end
        else
        begin
            s1_region_next = qsw_pkg::REGION_SWITCH;
        end
        s1_d_next = distance - cfg.start_distance;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_region_reg <= s1_region_next;
            s1_d_reg      <= s1_d_next;
        end
    end

    // Stage 2: multiply the offset by both halves of the reciprocal
    logic [55:0]       s2_lo_next;
    logic [55:0]       s2_lo_reg;
    logic [55:0]       s2_hi_next;
    logic [55:0]       s2_hi_reg;
    qsw_pkg::region_t  s2_region_reg;

    assign s2_lo_next = 56'(s1_d_reg)
                      * 56'(cfg.inverse_width[qsw_pkg::INV_SPLIT-1:0]);
    assign s2_hi_next = 56'(s1_d_reg)
                      * 56'(cfg.inverse_width[47:qsw_pkg::INV_SPLIT]);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_lo_reg     <= s2_lo_next;
            s2_hi_reg     <= s2_hi_next;
            s2_region_reg <= s1_region_reg;
        end
    end

    // Stage 3: combine the partial products, round and saturate u
    logic [56:0]       lo_sum;
    logic [40:0]       lo_part;
    logic [41:0]       u_sum;
    logic              u_sat;
    logic [31:0]       s3_u_next;
    logic [31:0]       s3_u_reg;
    qsw_pkg::region_t  s3_region_reg;

    always_comb
    begin
        lo_sum    = 57'(s2_lo_reg) + 57'(qsw_pkg::RND15);
        lo_part   = lo_sum[56:16];
        u_sum     = 42'({s2_hi_reg[23:0], 8'b0}) + 42'(lo_part);
        u_sat     = (|s2_hi_reg[55:24]) || (|u_sum[41:32]);
        s3_u_next = u_sat ? 32'hFFFF_FFFF : u_sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_u_reg      <= s3_u_next;
            s3_region_reg <= s2_region_reg;
        end
    end

    assign u      = s3_u_reg;
    assign region = s3_region_reg;

endmodule

>>> rtl/qsw_poly.sv
// Back stages: quintic weight polynomial, slope polynomial, reciprocal scaling
// and output selection. Depends on qsw_pkg for constants and region codes.
module qsw_poly
(
    input  logic                                 clk,
    input  logic [qsw_pkg::BACK_STAGES-1:0]      load,
    input  logic [47:0]                          inverse_width,
    input  logic [31:0]                          u,
    input  qsw_pkg::region_t                     region_in,
    output logic [32:0]                          weight,
    output logic signed [47:0]                   slope,
    output qsw_pkg::region_t                     region
);

    // Stage 4: u^2 and h = u(1-u)
    logic [63:0]       uu_sum;
    logic [32:0]       u_comp;
    logic [63:0]       h_sum;
    logic [31:0]       s4_u_reg;
    logic [31:0]       s4_u2_next;
    logic [31:0]       s4_u2_reg;
    logic [30:0]       s4_h_next;
    logic [30:0]       s4_h_reg;
    qsw_pkg::region_t  s4_region_reg;

    always_comb
    begin
        uu_sum     = 64'(u) * 64'(u) + 64'(qsw_pkg::RND31);
        s4_u2_next = uu_sum[63:32];
        u_comp     = qsw_pkg::ONE_Q32 - {1'b0, u};
        h_sum      = 64'(u) * 64'(u_comp) + 64'(qsw_pkg::RND31);
        s4_h_next  = h_sum[62:32];
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s4_u_reg      <= u;
            s4_u2_reg     <= s4_u2_next;
            s4_h_reg      <= s4_h_next;
            s4_region_reg <= region_in;
        end
    end

    // Stage 5: u^3, h^2 and q = 10 + 6u^2 - 15u
    logic [63:0]       u3_sum;
    logic [63:0]       hh_sum;
    logic [36:0]       q_pos;
    logic [36:0]       q_neg;
    logic [31:0]       s5_u3_next;
    logic [31:0]       s5_u3_reg;
    logic [28:0]       s5_hh_next;
    logic [28:0]       s5_hh_reg;
    logic [35:0]       s5_q_next;
    logic [35:0]       s5_q_reg;
    qsw_pkg::region_t  s5_region_reg;

    always_comb
    begin
        u3_sum     = 64'(s4_u2_reg) * 64'(s4_u_reg) + 64'(qsw_pkg::RND31);
        s5_u3_next = u3_sum[63:32];
        hh_sum     = 64'(s4_h_reg) * 64'(s4_h_reg) + 64'(qsw_pkg::RND31);
        s5_hh_next = hh_sum[60:32];
        q_pos      = qsw_pkg::TEN_Q32 + 37'(s4_u2_reg) * 37'(6);
        q_neg      = 37'(s4_u_reg) * 37'(15);
        s5_q_next  = (q_pos > q_neg) ? 36'(q_pos - q_neg) : 36'(0);
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s5_u3_reg     <= s5_u3_next;
            s5_hh_reg     <= s5_hh_next;
            s5_q_reg      <= s5_q_next;
            s5_region_reg <= s4_region_reg;
        end
    end

    // Stage 6: u^3 times integer and fraction parts of q, g = 30 h^2
    logic [63:0]       pf_sum;
    logic [35:0]       s6_pi_next;
    logic [35:0]       s6_pi_reg;
    logic [31:0]       s6_pf_next;
    logic [31:0]       s6_pf_reg;
    logic [32:0]       s6_g_next;
    logic [32:0]       s6_g_reg;
    qsw_pkg::region_t  s6_region_reg;

    always_comb
    begin
        s6_pi_next = 36'(s5_u3_reg) * 36'(s5_q_reg[35:32]);
        pf_sum     = 64'(s5_u3_reg) * 64'(s5_q_reg[31:0]) + 64'(qsw_pkg::RND31);
        s6_pf_next = pf_sum[63:32];
        s6_g_next  = 33'(s5_hh_reg) * 33'(30);
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s6_pi_reg     <= s6_pi_next;
            s6_pf_reg     <= s6_pf_next;
            s6_g_reg      <= s6_g_next;
            s6_region_reg <= s5_region_reg;
        end
    end

    // Stage 7: finish the weight, scale g by both reciprocal halves
    logic [36:0]       p_sum;
    logic [32:0]       s7_w_next;
    logic [32:0]       s7_w_reg;
    logic [56:0]       s7_a_next;
    logic [56:0]       s7_a_reg;
    logic [56:0]       s7_b_next;
    logic [56:0]       s7_b_reg;
    qsw_pkg::region_t  s7_region_reg;

    always_comb
    begin
        p_sum     = 37'(s6_pi_reg) + 37'(s6_pf_reg);
        s7_w_next = (p_sum >= 37'(qsw_pkg::ONE_Q32))
                  ? 33'(0) : 33'(37'(qsw_pkg::ONE_Q32) - p_sum);
        s7_a_next = 57'(s6_g_reg) * 57'(inverse_width[47:qsw_pkg::INV_SPLIT]);
        s7_b_next = 57'(s6_g_reg) * 57'(inverse_width[qsw_pkg::INV_SPLIT-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s7_w_reg      <= s7_w_next;
            s7_a_reg      <= s7_a_next;
            s7_b_reg      <= s7_b_next;
            s7_region_reg <= s6_region_reg;
        end
    end

    // Stage 8: slope magnitude, saturation and output selection
    logic [57:0]        m_sum;
    logic [57:0]        m_full;
    logic [47:0]        m_mag;
    logic [32:0]        weight_next;
    logic [32:0]        weight_reg;
    logic signed [47:0] slope_next;
    logic signed [47:0] slope_reg;
    qsw_pkg::region_t   region_reg;

    always_comb
    begin
        m_sum  = 58'(s7_a_reg) + 58'(s7_b_reg[56:qsw_pkg::INV_SPLIT]);
        m_full = m_sum >> qsw_pkg::SLOPE_SHIFT;
        m_mag  = (m_full > 58'(qsw_pkg::SLOPE_MAG_MAX))
               ? qsw_pkg::SLOPE_MAG_MAX : m_full[47:0];
        case (s7_region_reg)
            qsw_pkg::REGION_INSIDE:
            begin
                weight_next = qsw_pkg::ONE_Q32;
                slope_next  = '0;
            end
            qsw_pkg::REGION_SWITCH:
            begin
                weight_next = s7_w_reg;
                slope_next  = 48'(0) - m_mag;
            end
            default:
            begin
                weight_next = '0;
                slope_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            weight_reg <= weight_next;
            slope_reg  <= slope_next;
            region_reg <= s7_region_reg;
        end
    end

    assign weight = weight_reg;
    assign slope  = slope_reg;
    assign region = region_reg;

endmodule

>>> rtl/quintic_switch_with_derivative.sv
// Quintic switching weight S(r) and slope dS/dr over an eight-stage pipeline.
// Throughput: one transaction per cycle while out_stall is low, set by the fully
// pipelined multipliers, with bubbles squeezed out under output stall. Reset
// clears all pipeline valid bits and returns the configuration registers to
// start 0, width 1.0, reciprocal 2^32.
module quintic_switch_with_derivative
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        distance,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [32:0]        weight,
    output logic signed [47:0] slope,
    output logic [1:0]         region
);

    qsw_pkg::cfg_t                      cfg_reg;
    qsw_pkg::cfg_t                      cfg_next;
    logic [qsw_pkg::NUM_STAGES-1:0]     load;
    logic [31:0]                        u;
    qsw_pkg::region_t                   front_region;
    qsw_pkg::region_t                   out_region;

    // Decode configuration writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                qsw_pkg::REG_START_DISTANCE: cfg_next.start_distance = cfg_data[31:0];
                qsw_pkg::REG_SWITCH_WIDTH:   cfg_next.switch_width   = cfg_data[31:0];
                qsw_pkg::REG_INVERSE_WIDTH:  cfg_next.inverse_width  = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_distance <= qsw_pkg::START_DISTANCE_RST;
            cfg_reg.switch_width   <= qsw_pkg::SWITCH_WIDTH_RST;
            cfg_reg.inverse_width  <= qsw_pkg::INVERSE_WIDTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline flow control
    qsw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .load      (load)
    );

    // Region and unit position
    qsw_upos u_upos
    (
        .clk      (clk),
        .load     (load[qsw_pkg::FRONT_STAGES-1:0]),
        .cfg      (cfg_reg),
        .distance (distance),
        .u        (u),
        .region   (front_region)
    );

    // Weight and slope polynomials
    qsw_poly u_poly
    (
        .clk           (clk),
        .load          (load[qsw_pkg::NUM_STAGES-1:qsw_pkg::FRONT_STAGES]),
        .inverse_width (cfg_reg.inverse_width),
        .u             (u),
        .region_in     (front_region),
        .weight        (weight),
        .slope         (slope),
        .region        (out_region)
    );

    assign region = out_region;

endmodule
